// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmorph_pkg.sv =====
// ----------------------------------------------------------------------------
// bmorph_pkg
// Shared types and constants of the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmorph_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int MIN_DIM      = 3;
    localparam int PIX_W        = 8;

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // per-pixel flags kept in the line stores and the window
    localparam int FLAG_W       = 2;
    localparam int FLAG_FULL    = 0;
    localparam int FLAG_NONZERO = 1;
    localparam int LS_W         = 2 * FLAG_W;

    localparam int WIN_CELLS    = 9;
    // cells 1,3,4,5,7 of the 3x3 window
    localparam logic [WIN_CELLS-1:0] CROSS_MASK = 9'b010111010;
    localparam logic [WIN_CELLS-1:0] SQUARE_MASK = '1;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

    localparam logic MODE_DILATE = 1'b1;
    localparam logic ACT_DRAIN   = 1'b1;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_CONN   = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_in_frame;
    } out_item_t;

    typedef struct packed {
        logic             operation_mode;
        logic             eight_connected;
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic              shift;
        logic              emit;
        logic              interior;
        logic              last;
        logic [FLAG_W-1:0] flags;
        logic [COL_W-1:0]  addr;
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [FLAG_W-1:0] upper;
        logic [FLAG_W-1:0] middle;
    } qentry_t;

endpackage

`default_nettype wire

// ===== rtl/bmorph_ram.sv =====
// ----------------------------------------------------------------------------
// bmorph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmorph_regs.sv =====
// ----------------------------------------------------------------------------
// bmorph_regs
// APB register file: mode, connectivity and frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bmorph_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bmorph_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bmorph_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                     pready,
    output bmorph_pkg::cfg_t                         cfg
);

    import bmorph_pkg::*;

    logic                    mode_reg;
    logic                    conn_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    wr;
    reg_idx_t                idx;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            conn_reg   <= 1'b1;
            width_reg  <= WIDTH_REG_W'(640);
            height_reg <= HEIGHT_REG_W'(480);
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_CONN:   conn_reg   <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            REG_CONN:   prdata = APB_DATA_W'(conn_reg);
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // saturate frame size to the supported range
    always_comb
    begin
        priority if (width_reg < WIDTH_REG_W'(MIN_DIM))
            w_eff = WIDTH_REG_W'(MIN_DIM);
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        priority if (height_reg < HEIGHT_REG_W'(MIN_DIM))
            h_eff = HEIGHT_REG_W'(MIN_DIM);
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign cfg.operation_mode  = mode_reg;
    assign cfg.eight_connected = conn_reg;
    assign cfg.col_last        = COL_W'(w_eff - WIDTH_REG_W'(1));
    assign cfg.row_last        = ROW_W'(h_eff - HEIGHT_REG_W'(1));
    assign cfg.restart         = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

endmodule

`default_nettype wire

// ===== rtl/bmorph_front.sv =====
// ----------------------------------------------------------------------------
// bmorph_front
// Input side: raster counters, beat classification and the line stores.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bmorph_pkg::cfg_t      cfg,
    input  wire logic                  pix_valid,
    output logic                       pix_ready,
    input  wire bmorph_pkg::in_item_t  pix_data,
    output logic                       q_push,
    input  wire logic                  q_ready,
    output bmorph_pkg::qentry_t        q_entry
);

    import bmorph_pkg::*;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             full_reg, full_next;
    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg, s1_cmd_next;

    logic             fire;
    logic             is_pixel;
    logic             primed;
    logic             do_emit;
    cmd_t             cmd;
    logic [LS_W-1:0]  ls_rdata;
    logic [LS_W-1:0]  ls_wdata;

    assign q_push    = s1_valid_reg && q_ready;
    assign pix_ready = !s1_valid_reg || q_ready;
    assign fire      = pix_valid && pix_ready;
    assign is_pixel  = !full_reg && (pix_data.action != ACT_DRAIN);
    // results start once the pixel one row and one column ahead arrives
    assign primed    = (in_row_reg != '0)
                       && ((in_row_reg != ROW_W'(1)) || (in_col_reg != '0));
    assign do_emit   = full_reg || (is_pixel && primed);

    always_comb
    begin
        cmd.shift    = is_pixel;
        cmd.emit     = do_emit;
        cmd.interior = (out_row_reg != '0) && (out_row_reg != cfg.row_last)
                       && (out_col_reg != '0) && (out_col_reg != cfg.col_last);
        cmd.last     = (out_row_reg == cfg.row_last) && (out_col_reg == cfg.col_last);
        cmd.flags[FLAG_FULL]    = (pix_data.pixel_in == PIX_WHITE);
        cmd.flags[FLAG_NONZERO] = (pix_data.pixel_in != PIX_BLACK);
        cmd.addr     = in_col_reg;
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        full_next     = full_reg;
        s1_valid_next = s1_valid_reg;
        s1_cmd_next   = s1_cmd_reg;

        if (q_push)
        begin
            s1_valid_next = 1'b0;
        end

        if (cfg.restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            full_next    = 1'b0;
        end
        else if (fire)
        begin
            if (is_pixel || full_reg)
            begin
                s1_valid_next = 1'b1;
                s1_cmd_next   = cmd;
            end
            if (is_pixel)
            begin
                if (in_col_reg == cfg.col_last)
                begin
                    in_col_next = '0;
                    if (in_row_reg == cfg.row_last)
                    begin
                        in_row_next = '0;
                        full_next   = 1'b1;
                    end
                    else
                    begin
                        in_row_next = ROW_W'(in_row_reg + 1'b1);
                    end
                end
                else
                begin
                    in_col_next = COL_W'(in_col_reg + 1'b1);
                end
            end
            if (do_emit)
            begin
                if (cmd.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    full_next    = 1'b0;
                end
                else if (out_col_reg == cfg.col_last)
                begin
                    out_col_next = '0;
                    out_row_next = ROW_W'(out_row_reg + 1'b1);
                end
                else
                begin
                    out_col_next = COL_W'(out_col_reg + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            full_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            full_reg     <= full_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= s1_cmd_next;
    end

    // Both line stores in one RAM: {upper, middle}. Read on accept, write
    // back {middle, new} when the beat leaves for the queue. Read data holds
    // while the stage is stalled since no new read issues then.
    assign ls_wdata = {ls_rdata[FLAG_W-1:0], s1_cmd_reg.flags};

    bmorph_ram #(
        .DATA_W (LS_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (q_push && s1_cmd_reg.shift),
        .waddr (s1_cmd_reg.addr),
        .wdata (ls_wdata),
        .re    (fire && is_pixel && !cfg.restart),
        .raddr (in_col_reg),
        .rdata (ls_rdata)
    );

    assign q_entry.cmd    = s1_cmd_reg;
    assign q_entry.upper  = ls_rdata[LS_W-1:FLAG_W];
    assign q_entry.middle = ls_rdata[FLAG_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/bmorph_queue.sv =====
// ----------------------------------------------------------------------------
// bmorph_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bmorph_pkg::qentry_t  push_data,
    output logic                      push_ready,
    output logic                      pop_valid,
    input  wire logic                 pop,
    output bmorph_pkg::qentry_t       pop_data
);

    import bmorph_pkg::*;

    qentry_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                          ? '0 : QUEUE_AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                          ? '0 : QUEUE_AW'(rd_ptr_reg + 1'b1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = QUEUE_CW'(count_reg + 1'b1);
            2'b01:   count_next = QUEUE_CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmorph_back.sv =====
// ----------------------------------------------------------------------------
// bmorph_back
// Output side: 3x3 flag window, erosion/dilation decision, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmorph_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bmorph_pkg::cfg_t     cfg,
    input  wire logic                 q_valid,
    input  wire bmorph_pkg::qentry_t  q_entry,
    output logic                      q_pop,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output bmorph_pkg::out_item_t     res_data
);

    import bmorph_pkg::*;

    logic [FLAG_W-1:0]    win_reg [WIN_CELLS];
    logic [FLAG_W-1:0]    win_next [WIN_CELLS];
    logic [WIN_CELLS-1:0] full_vec;
    logic [WIN_CELLS-1:0] nz_vec;
    logic [WIN_CELLS-1:0] mask;
    logic                 all_full;
    logic                 any_nz;
    logic [PIX_W-1:0]     result;
    logic                 res_valid_reg, res_valid_next;
    out_item_t            res_data_reg, res_data_next;
    logic                 load;

    // beats without a result never wait on the output register
    assign q_pop = q_valid && (!q_entry.cmd.emit || !res_valid_reg || res_ready);
    assign load  = q_pop && q_entry.cmd.emit;

    // cell 3*row+col, row 0 the oldest line, col 0 the oldest column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[3*r]   = q_entry.cmd.shift ? win_reg[3*r+1] : win_reg[3*r];
            win_next[3*r+1] = q_entry.cmd.shift ? win_reg[3*r+2] : win_reg[3*r+1];
        end
        win_next[2] = q_entry.cmd.shift ? q_entry.upper     : win_reg[2];
        win_next[5] = q_entry.cmd.shift ? q_entry.middle    : win_reg[5];
        win_next[8] = q_entry.cmd.shift ? q_entry.cmd.flags : win_reg[8];
    end

    always_comb
    begin
        for (int i = 0; i < WIN_CELLS; i++)
        begin
            full_vec[i] = win_next[i][FLAG_FULL];
            nz_vec[i]   = win_next[i][FLAG_NONZERO];
        end
    end

    assign mask     = cfg.eight_connected ? SQUARE_MASK : CROSS_MASK;
    assign all_full = &(full_vec | ~mask);
    assign any_nz   = |(nz_vec & mask);

    always_comb
    begin
        priority if (!q_entry.cmd.interior)
            result = PIX_WHITE;
        else if (cfg.operation_mode == MODE_DILATE)
            result = any_nz ? PIX_WHITE : PIX_BLACK;
        else
            result = all_full ? PIX_WHITE : PIX_BLACK;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (load)
        begin
            res_valid_next              = 1'b1;
            res_data_next.pixel_out     = result;
            res_data_next.last_in_frame = q_entry.cmd.last;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg.restart || (load && q_entry.cmd.last))
            begin
                for (int i = 0; i < WIN_CELLS; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else if (q_pop)
            begin
                for (int i = 0; i < WIN_CELLS; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire

// ===== rtl/binary_morphology_3x3_top.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_3x3_top: 3x3 binary erosion/dilation on a raster stream
// Beats pass the front stage register, the queue and the result register.
// Throughput: one beat per cycle with the output free; the line-store RAM
// is read once and written once per pixel. Reset: mode erosion, 8-connected,
// 640x480; line stores are not cleared and hold no valid data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morphology_3x3_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                pix_valid,
    output logic                                     pix_ready,
    input  wire bmorph_pkg::in_item_t                pix_data,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output bmorph_pkg::out_item_t                    res_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bmorph_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bmorph_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bmorph_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                     pready
);

    import bmorph_pkg::*;

    cfg_t    cfg;
    logic    q_push;
    logic    q_ready;
    qentry_t q_in;
    logic    q_valid;
    logic    q_pop;
    qentry_t q_out;

    bmorph_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmorph_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_entry   (q_in)
    );

    bmorph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_out)
    );

    bmorph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire

// ===== rtl/bmorph_checker.sv =====
// ----------------------------------------------------------------------------
// bmorph_checker
// Port-level checks on the morphology top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmorph_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   pix_ready,
    input wire logic                   res_valid,
    input wire logic                   res_ready,
    input wire bmorph_pkg::out_item_t  res_data
);

    import bmorph_pkg::*;

    `BM_ASSERT_NEXT(a_res_valid_held, clk, rst_n, res_valid && !res_ready, res_valid, "result beat dropped while stalled")

    `BM_ASSERT_NEXT(a_res_data_held, clk, rst_n, res_valid && !res_ready, $stable(res_data), "result payload changed while stalled")

    `BM_ASSERT_IMPLY(a_res_binary, clk, rst_n, res_valid, res_data.pixel_out == PIX_WHITE || res_data.pixel_out == PIX_BLACK, "result pixel not binary")

    // an open output in the previous cycle drains the queue enough to take a beat
    `BM_ASSERT_IMPLY(a_ready_after_drain, clk, rst_n, $past(res_ready), pix_ready, "input stalled with output open")

endmodule

bind binary_morphology_3x3_top bmorph_checker u_checker (.*);

`default_nettype wire
